// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker modules of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted (active low).
`define PPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("ppc assertion failed");

// Clocked property that also holds during reset.
`define PPC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ppc assertion failed");

`endif

// ----- rtl/core/ppc_pkg.sv -----
// Shared constants and types of the patience pile counter.
// No dependencies.
package ppc_pkg;

    localparam int unsigned MAX_PILES_DEF = 1024;
    localparam int unsigned DW            = 32;
    localparam int unsigned PCW           = 11;

    typedef struct packed {
        logic [PCW-1:0] pile_count;
        logic           overflow;
    } t_res;

endpackage

// ----- rtl/core/ppc_tail_mem.sv -----
// Synchronous tail memory, one write port and one read port, with a registered read.
// Depends on ppc_pkg.
module ppc_tail_mem
    import ppc_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_PILES_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/ppc_search.sv -----
// Binary search sequencer: searches the tail memory, then replaces or appends a tail.
// Depends on ppc_pkg; drives ppc_tail_mem.
module ppc_search
    import ppc_pkg::*;
#(
    parameter int unsigned MAX_PILES = MAX_PILES_DEF,
    parameter int unsigned AW        = $clog2(MAX_PILES),
    parameter int unsigned CW        = $clog2(MAX_PILES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_value,
    input  logic                 i_start_req,
    output logic                 o_busy,
    output logic                 o_res_valid,
    output t_res                 o_res,
    input  logic                 i_res_take,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [DW-1:0]        i_rd_data,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [DW-1:0]        o_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_WRITE  = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_PILES);

    t_state        r_state, n_state;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_count, n_count;
    logic [DW-1:0] r_value, n_value;
    t_res          r_res, n_res;

    logic          less;
    logic [CW-1:0] s_lo, s_hi;
    logic [CW-1:0] n0;
    logic          found;
    logic [CW+PCW-1:0] cnt_ext;

    assign less  = $signed(i_rd_data) < $signed(r_value);
    assign s_lo  = less ? r_lo : r_mid + 1'b1;
    assign s_hi  = less ? r_mid : r_hi;
    assign n0    = i_start_req ? '0 : r_count;
    assign found = r_lo != r_n;

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_n     = r_n;
        n_count = r_count;
        n_value = r_value;
        n_res   = r_res;
        cnt_ext = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_value = i_value;
                    n_n     = n0;
                    n_lo    = '0;
                    n_hi    = n0;
                    n_mid   = n0 >> 1;
                    n_state = (n0 == '0) ? S_WRITE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                // Tail at r_mid is on the read port now; narrow the window.
                n_lo  = s_lo;
                n_hi  = s_hi;
                n_mid = s_lo + ((s_hi - s_lo) >> 1);
                if (s_lo >= s_hi) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!found && r_n != MAX_C) begin
                    n_count = r_n + 1'b1;
                end else begin
                    n_count = r_n;
                end
                cnt_ext          = {{PCW{1'b0}}, n_count};
                n_res.pile_count = cnt_ext[PCW-1:0];
                n_res.overflow   = !found && r_n == MAX_C;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_n     <= n_n;
        r_value <= n_value;
        r_res   <= n_res;
    end

    // The replace index and the append index are both the final low bound.
    assign o_rd_addr   = n_mid[AW-1:0];
    assign o_wr_en     = (r_state == S_WRITE) && (found || r_n != MAX_C);
    assign o_wr_addr   = r_lo[AW-1:0];
    assign o_wr_data   = r_value;
    assign o_busy      = r_state != S_IDLE;
    assign o_res_valid = r_state == S_DONE;
    assign o_res       = r_res;

endmodule

// ----- rtl/core/patience_pile_counter_top.sv -----
// Top level of the patience pile counter: search sequencer, tail memory, output register.
// Depends on ppc_pkg, ppc_tail_mem and ppc_search.
//
//  Channel | Direction | Handshake               | Fields
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_value, i_start_req
//  out     | output    | o_out_valid/i_out_stall | o_pile_count, o_overflow
//
// An accepted item runs the binary search over the stored tails (none on an empty
// table) and then a write step, after which its result waits to be loaded.
// The input stays stalled until that result has been loaded, so the block takes
// no new item before it is through with the last one.
// Each binary search step is one read of the tail memory, and the compare on the
// read data picks the next address in the same cycle.
// Reset is synchronous and active low; it clears the sequencer and the pile count.
// The tail memory is not cleared; only tails below the pile count are ever used.
// A stalled result sits in the output register while the next item is searched.
module patience_pile_counter_top
    import ppc_pkg::*;
#(
    parameter int unsigned MAX_PILES = MAX_PILES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [DW-1:0]  i_value,
    input  logic                  i_start_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PCW-1:0]        o_pile_count,
    output logic                  o_overflow
);

    localparam int unsigned AW = $clog2(MAX_PILES);
    localparam int unsigned CW = $clog2(MAX_PILES + 1);

    logic          busy;
    logic          res_valid;
    t_res          res;
    logic          res_take;
    logic          in_accept;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    logic          r_out_valid;
    t_res          r_out;

    // The sequencer takes a new item only when it has nothing in flight.
    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !busy;

    // A finished result moves into the output register once that is free.
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    ppc_search #(
        .MAX_PILES (MAX_PILES),
        .AW        (AW),
        .CW        (CW)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_value     (i_value),
        .i_start_req (i_start_req),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    ppc_tail_mem #(
        .DEPTH (MAX_PILES),
        .AW    (AW)
    ) u_tail_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pile_count = r_out.pile_count;
    assign o_overflow   = r_out.overflow;

endmodule

// ----- rtl/core/ppc_checker.sv -----
// Port-level checker of the patience pile counter, bound to the top level.
// Depends on ppc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppc_checker
    import ppc_pkg::*;
#(
    parameter int unsigned MAX_PILES = MAX_PILES_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input logic [PCW-1:0] o_pile_count,
    input logic           o_overflow
);

    localparam int unsigned MAX_MASKED = MAX_PILES % (1 << PCW);

    // A held result must not change under stall.
    `PPC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pile_count) && $stable(o_overflow))

    // Overflow only occurs with a full table.
    `PPC_ASSERT(a_ovf_full, i_clk, i_rst_n, o_out_valid && o_overflow |-> o_pile_count == PCW'(MAX_MASKED))

    // After an item is taken the block is busy with it.
    `PPC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall)

    // A new result is loaded only at the end of an item's search.
    `PPC_ASSERT(a_res_from_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall))

    // Out of reset nothing is shown.
    `PPC_ASSERT_NR(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind patience_pile_counter_top ppc_checker #(
    .MAX_PILES (MAX_PILES)
) u_ppc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_pile_count (o_pile_count),
    .o_overflow   (o_overflow)
);

// ----- bench/tb_patience_pile_counter_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for patience_pile_counter_top: a pile predictor, random idling.
// Depends on ppc_pkg and on the RTL of patience_pile_counter_top.
module tb_patience_pile_counter_top;
    import ppc_pkg::*;

    // Clock, reset and every input of the block start at known values.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic signed [DW-1:0] i_value     = '0;
    logic                 i_start_req = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [PCW-1:0]       o_pile_count;
    logic                 o_overflow;

    patience_pile_counter_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_start_req  (i_start_req),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pile_count (o_pile_count),
        .o_overflow   (o_overflow)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: one tail per pile, tails non-increasing from pile 0 upward.
    // Only entries below piles_in_use are ever read, so the array needs no clearing.
    logic signed [DW-1:0] pile_tail [MAX_PILES_DEF];
    int                   piles_in_use = 0;

    // Pile counts still owed by the block, oldest first.
    t_res expected_piles [$];

    int  bad_results = 0;
    int  items_sent  = 0;

    // Sender state. valid_up mirrors i_in_valid so that the valid line never gets
    // two nonblocking assignments within one time step.
    bit  valid_up   = 1'b0;
    int  burst_left = 0;
    int  gap_left   = 0;

    // Receiver state. A test raises hold_req to ask for one long stall.
    bit  hold_req    = 1'b0;
    int  hold_left   = 0;
    int  stall_cycle = 0;
    int  stall_mode  = 0;

    // Places one value the way patience sorting does and returns the pile count
    // that the block has to report for it. A start request empties the table first.
    // The binary search looks for the first tail strictly below the value; on a hit
    // that tail is replaced, on a miss a new pile opens unless the table is full.
    function automatic t_res place_on_piles(input logic signed [DW-1:0] v, input logic s);
        int   lo;
        int   hi;
        int   mid;
        t_res r;
        if (s) begin
            piles_in_use = 0;
        end
        lo = 0;
        hi = piles_in_use;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (pile_tail[mid] < v) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        r.overflow = 1'b0;
        if (lo < piles_in_use) begin
            pile_tail[lo] = v;
        end else if (piles_in_use < MAX_PILES_DEF) begin
            pile_tail[piles_in_use] = v;
            piles_in_use++;
        end else begin
            r.overflow = 1'b1;
        end
        r.pile_count = PCW'(piles_in_use);
        return r;
    endfunction

    // Offers one item and returns at the edge that accepts it. The sender works in
    // bursts: when a burst runs out, valid drops and a random gap follows. Some
    // bursts are long, which gives stretches with no idling on the input side.
    task automatic offer_value(input logic signed [DW-1:0] v, input logic s);
        if (gap_left > 0) begin
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        i_value     <= v;
        i_start_req <= s;
        if (!valid_up) begin
            i_in_valid <= 1'b1;
            valid_up   = 1'b1;
        end
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        // Accepted at this edge: the payload stays put until now.
        expected_piles.push_back(place_on_piles(v, s));
        items_sent++;
        burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            valid_up   = 1'b0;
            gap_left   = $urandom_range(1, 15);
        end
    endtask

    // Stops offering items and waits until every expected result has come back.
    task automatic pause_until_drained();
        if (valid_up) begin
            i_in_valid <= 1'b0;
            valid_up   = 1'b0;
        end
        burst_left = 0;
        gap_left   = 0;
        @(posedge i_clk);
        while (expected_piles.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Extremes of the value range, equal values, a start in the middle of a
    // sequence and tails that get replaced rather than extended.
    task automatic test_directed();
        offer_value(32'sd0, 1'b1);             // start with a value: one pile
        offer_value(32'sh7FFF_FFFF, 1'b0);     // larger than the tail, replaces it
        offer_value(32'sh7FFF_FFFF, 1'b0);     // equal to the tail opens a new pile
        offer_value(32'sh8000_0000, 1'b0);     // most negative value, new pile
        offer_value(32'sh8000_0000, 1'b0);     // equal at the bottom, new pile
        offer_value(-32'sd1, 1'b0);            // replaces the first negative tail
        offer_value(32'sh7FFF_FFFE, 1'b0);     // replaces a tail below it
        offer_value(32'sh8000_0001, 1'b0);
        offer_value(32'sh8000_0000, 1'b0);
        offer_value(32'sh7FFF_FFFF, 1'b1);     // start in the middle of a sequence
        offer_value(32'sh8000_0000, 1'b0);
        offer_value(32'sh7FFF_FFFF, 1'b0);
        offer_value(32'sh5555_5555, 1'b1);
        offer_value(32'shAAAA_AAAA, 1'b0);     // negative pattern, new pile
        offer_value(32'sh5555_5555, 1'b0);     // replaces the negative tail
        offer_value(32'sh5555_5555, 1'b0);     // equal, new pile
        offer_value(32'sd1, 1'b0);
        offer_value(32'sd0, 1'b0);
        offer_value(-32'sd1, 1'b0);
        offer_value(32'sd0, 1'b0);             // replaces the tail of -1
        pause_until_drained();
    endtask

    // Fills all piles with a non-increasing run, then pushes past capacity. Values
    // that need a new pile on a full table are dropped and flag overflow; a value
    // that replaces a tail never does. The receiver holds off for a long stretch
    // early on, so the block fills up and must stall its input.
    task automatic test_fill_and_overflow();
        longint run_value;
        run_value = 64'sd2147483647;
        for (int i = 0; i < MAX_PILES_DEF + 6; i++) begin
            if (i == 150) begin
                hold_req = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                run_value = run_value - longint'($urandom_range(1, 3_000_000));
                if (run_value < -64'sd2147483648) begin
                    run_value = -64'sd2147483648;
                end
            end
            offer_value(DW'(run_value), i == 0);
        end
        offer_value(32'sh7FFF_FFFF, 1'b0);     // replaces a tail on a full table
        offer_value(DW'(run_value), 1'b0);     // needs a new pile again: overflow
        offer_value(32'sh8000_0000, 1'b0);
        pause_until_drained();
    endtask

    // Random sequences: most start cleanly and carry random content of several
    // kinds; a few continue the previous table or see a stray start request.
    task automatic test_random_sequences();
        int                   seq_len;
        int                   content;
        logic                 start_now;
        logic signed [DW-1:0] v;
        longint               trend;
        while (items_sent < 1550) begin
            seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 40);
            content = $urandom_range(0, 3);
            trend   = longint'($signed($urandom));
            for (int i = 0; i < seq_len; i++) begin
                case (content)
                    0: v = $urandom;
                    1: v = $signed($urandom_range(0, 8)) - 32'sd4;
                    2: begin
                        // Downward drift with occasional jumps up.
                        if ($urandom_range(0, 3) == 0) begin
                            trend = trend + longint'($urandom_range(0, 1_000_000));
                        end else begin
                            trend = trend - longint'($urandom_range(0, 1_000));
                        end
                        if (trend > 64'sd2147483647) begin
                            trend = 64'sd2147483647;
                        end
                        if (trend < -64'sd2147483648) begin
                            trend = -64'sd2147483648;
                        end
                        v = DW'(trend);
                    end
                    default: begin
                        // Values at and next to the ends of the range and zero.
                        case ($urandom_range(0, 6))
                            0: v = 32'sh8000_0000;
                            1: v = 32'sh8000_0001;
                            2: v = -32'sd1;
                            3: v = 32'sd0;
                            4: v = 32'sd1;
                            5: v = 32'sh7FFF_FFFE;
                            default: v = 32'sh7FFF_FFFF;
                        endcase
                    end
                endcase
                if (i == 0) begin
                    start_now = ($urandom_range(0, 9) != 0);
                end else begin
                    start_now = ($urandom_range(0, 39) == 0);
                end
                offer_value(v, start_now);
            end
            if ($urandom_range(0, 5) == 0) begin
                pause_until_drained();
            end
        end
        pause_until_drained();
    endtask

    // Receiver: the stall pattern is a mode picked at random out of no stall,
    // light and heavy random stalls and a fixed two-in-three pattern. A hold
    // request from a test overrides all of it for one long stall.
    always @(posedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 80 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 9) < 6);
                default: i_out_stall <= (stall_cycle % 3 != 0);
            endcase
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // expectation, field by field. Only the first ten problems are printed.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_piles.size() == 0) begin
                if (bad_results < 10) begin
                    $display("unexpected result: pile_count=%0d overflow=%0b",
                             o_pile_count, o_overflow);
                end
                bad_results++;
            end else begin
                want = expected_piles.pop_front();
                if (o_pile_count !== want.pile_count || o_overflow !== want.overflow) begin
                    if (bad_results < 10) begin
                        $display("mismatch: pile_count exp %0d got %0d, overflow exp %0b got %0b",
                                 want.pile_count, o_pile_count, want.overflow, o_overflow);
                    end
                    bad_results++;
                end
            end
        end
    end

    // Stimulus: reset once, then the tests in turn, then a quiet tail so that a
    // stray extra result would still be caught.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_overflow();
        test_random_sequences();
        pause_until_drained();
        repeat (40) @(posedge i_clk);
        if (bad_results == 0 && expected_piles.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial begin
        #(20_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
